### rtl/core/cprd_pkg.sv
// Shared types and constants of the camera primary ray direction unit.
// No dependencies; every other file of the block refers to it by scoped names.
package cprd_pkg;

   localparam int COMP_W   = 16;   // one packed Q4.12 component
   localparam int REG_W    = 48;   // three packed components
   localparam int JIT_W    = 16;   // Q0.16 jitter
   localparam int NORM_W   = 30;   // the largest normalized magnitude lies in [2^29, 2^30)
   localparam int NORM_TOP = 29;
   localparam int SUM_W    = 64;   // sum of squares and root work width
   localparam int LEN_W    = 32;   // vector length
   localparam int DIV_W    = 48;   // dividend and partial remainder width
   localparam int Q_W      = 16;   // quotient and output width
   localparam int FRAC_W   = 14;   // Q1.14 fraction
   localparam int CSR_IDX_W = 3;

   localparam logic [Q_W-1:0] Q_ONE = 16'd16384;

   localparam logic [REG_W-1:0] CAMERA_POSITION_RST = 48'd1610612736;
   localparam logic [REG_W-1:0] FRAME_CORNER_RST    = 48'd17593259790336;
   localparam logic [REG_W-1:0] COLUMN_STEP_RST     = 48'd65504;
   localparam logic [REG_W-1:0] ROW_STEP_RST        = 48'd281337537757184;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_POSITION = 3'd0,
      CSR_FRAME_CORNER    = 3'd1,
      CSR_COLUMN_STEP     = 3'd2,
      CSR_ROW_STEP        = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [Q_W-1:0] dir_x;
      logic signed [Q_W-1:0] dir_y;
      logic signed [Q_W-1:0] dir_z;
      logic                  degenerate;
   } rsp_type;

endpackage

### rtl/core/cprd_isqrt.sv
// Pipelined integer square root, two result bits per stage, with a sideband.
// Depends on cprd_pkg for the work width.
module cprd_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [cprd_pkg::SUM_W-1:0]   in_value,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [cprd_pkg::LEN_W-1:0]   out_root,
   output logic [SIDE_W-1:0]            out_side
);

   localparam int W      = cprd_pkg::SUM_W;
   localparam int STEPS  = W / 2;
   localparam int PER    = 2;
   localparam int NST    = STEPS / PER;

   logic [W-1:0]      rem_ff  [NST];
   logic [W-1:0]      root_ff [NST];
   logic [SIDE_W-1:0] side_ff [NST];
   logic [NST-1:0]    valid_ff;

   genvar g;
   generate
      for (g = 0; g < NST; g++) begin : g_stage
         logic [W-1:0] rem_prev, root_prev, rem_in, root_in, bit_v;
         assign rem_prev  = (g == 0) ? in_value : rem_ff[(g == 0) ? 0 : g-1];
         assign root_prev = (g == 0) ? '0 : root_ff[(g == 0) ? 0 : g-1];

         // Each step tries the next power of four against the remainder.
         always_comb begin
            rem_in  = rem_prev;
            root_in = root_prev;
            bit_v   = '0;
            for (int j = 0; j < PER; j++) begin
               bit_v = W'(1) << (W - 2 - 2 * (PER * g + j));
               if (rem_in >= root_in + bit_v) begin
                  rem_in  = rem_in - (root_in + bit_v);
                  root_in = (root_in >> 1) + bit_v;
               end else begin
                  root_in = root_in >> 1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g]  <= rem_in;
               root_ff[g] <= root_in;
               side_ff[g] <= (g == 0) ? in_side : side_ff[(g == 0) ? 0 : g-1];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else if (en) begin
               valid_ff[g] <= (g == 0) ? in_valid : valid_ff[(g == 0) ? 0 : g-1];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NST-1];
   assign out_root  = root_ff[NST-1][cprd_pkg::LEN_W-1:0];
   assign out_side  = side_ff[NST-1];

endmodule

### rtl/core/cprd_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, two quotient
// bits per stage, with a sideband. Depends on cprd_pkg for widths.
module cprd_div #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [cprd_pkg::DIV_W-1:0]   in_num [3],
   input  logic [cprd_pkg::LEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [cprd_pkg::Q_W-1:0]     out_quo [3],
   output logic [SIDE_W-1:0]            out_side
);

   localparam int DW  = cprd_pkg::DIV_W;
   localparam int QW  = cprd_pkg::Q_W;
   localparam int PER = 2;
   localparam int NST = QW / PER;

   logic [DW-1:0]                rem_ff  [NST][3];
   logic [QW-1:0]                quo_ff  [NST][3];
   logic [cprd_pkg::LEN_W-1:0]   den_ff  [NST];
   logic [SIDE_W-1:0]            side_ff [NST];
   logic [NST-1:0]               valid_ff;

   genvar g, k;
   generate
      for (g = 0; g < NST; g++) begin : g_stage
         logic [cprd_pkg::LEN_W-1:0] den_prev;
         assign den_prev = (g == 0) ? in_den : den_ff[(g == 0) ? 0 : g-1];

         for (k = 0; k < 3; k++) begin : g_lane
            logic [DW-1:0] rem_prev, rem_in, trial;
            logic [QW-1:0] quo_prev, quo_in;
            assign rem_prev = (g == 0) ? in_num[k] : rem_ff[(g == 0) ? 0 : g-1][k];
            assign quo_prev = (g == 0) ? '0 : quo_ff[(g == 0) ? 0 : g-1][k];

            always_comb begin
               rem_in = rem_prev;
               quo_in = quo_prev;
               trial  = '0;
               for (int j = 0; j < PER; j++) begin
                  trial  = DW'(den_prev) << (QW - 1 - (PER * g + j));
                  quo_in = quo_in << 1;
                  if (rem_in >= trial) begin
                     rem_in    = rem_in - trial;
                     quo_in[0] = 1'b1;
                  end
               end
            end

            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[g][k] <= rem_in;
                  quo_ff[g][k] <= quo_in;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[g]  <= den_prev;
               side_ff[g] <= (g == 0) ? in_side : side_ff[(g == 0) ? 0 : g-1];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else if (en) begin
               valid_ff[g] <= (g == 0) ? in_valid : valid_ff[(g == 0) ? 0 : g-1];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NST-1];
   assign out_quo   = quo_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

### rtl/core/camera_primary_ray_direction_unit.sv
// Camera primary ray direction: one beat per cycle sustained while the skid entry
// of the output buffer is empty (a full skid entry holds req_ready low), set by the
// fully pipelined multiply, square root (16 stages) and divide (8 stages) paths.
// A two-entry output buffer lets the pipeline run while a response waits.
// Synchronous active-high reset clears all valid bits and loads register defaults.
// Depends on cprd_pkg, cprd_isqrt and cprd_div.
module camera_primary_ray_direction_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [COORD_BITS-1:0]                req_column,
   input  logic [COORD_BITS-1:0]                req_row,
   input  logic [cprd_pkg::JIT_W-1:0]           req_jitter_x,
   input  logic [cprd_pkg::JIT_W-1:0]           req_jitter_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cprd_pkg::Q_W-1:0]      rsp_dir_x,
   output logic signed [cprd_pkg::Q_W-1:0]      rsp_dir_y,
   output logic signed [cprd_pkg::Q_W-1:0]      rsp_dir_z,
   output logic                                 rsp_degenerate,
   input  logic                                 csr_we,
   input  logic [cprd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cprd_pkg::REG_W-1:0]           csr_wdata
);

   localparam int CW     = cprd_pkg::COMP_W;
   localparam int CRD_W  = COORD_BITS + cprd_pkg::JIT_W;
   localparam int PRD_W  = CRD_W + CW + 1;
   localparam int D_W    = PRD_W + 2;
   localparam int POS_W  = $clog2(D_W);
   localparam int NW     = cprd_pkg::NORM_W;
   localparam int SQ_W   = 2 * NW;
   localparam int SIDE_S = 3 * NW + 4;
   localparam int SIDE_D = 4;

   // Configuration registers.
   logic [cprd_pkg::REG_W-1:0] cam_ff, cor_ff, cstep_ff, rstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff   <= cprd_pkg::CAMERA_POSITION_RST;
         cor_ff   <= cprd_pkg::FRAME_CORNER_RST;
         cstep_ff <= cprd_pkg::COLUMN_STEP_RST;
         rstep_ff <= cprd_pkg::ROW_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            cprd_pkg::CSR_CAMERA_POSITION: cam_ff   <= csr_wdata;
            cprd_pkg::CSR_FRAME_CORNER:    cor_ff   <= csr_wdata;
            cprd_pkg::CSR_COLUMN_STEP:     cstep_ff <= csr_wdata;
            cprd_pkg::CSR_ROW_STEP:        rstep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_valid_ff;
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // Stage 1: step products and corner minus camera.
   logic [CRD_W-1:0]         cx, cy;
   logic signed [PRD_W-1:0]  pc_in [3], pr_in [3];
   logic signed [CW:0]       base_in [3];
   logic signed [PRD_W-1:0]  s1_pc_ff [3], s1_pr_ff [3];
   logic signed [CW:0]       s1_base_ff [3];
   logic                     s1_valid_ff;

   assign cx = {req_column, req_jitter_x};
   assign cy = {req_row, req_jitter_y};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pc_in[k]   = $signed(cstep_ff[CW*k +: CW]) * $signed({1'b0, cx});
         pr_in[k]   = $signed(rstep_ff[CW*k +: CW]) * $signed({1'b0, cy});
         base_in[k] = $signed({cor_ff[CW*k+CW-1], cor_ff[CW*k +: CW]})
                    - $signed({cam_ff[CW*k+CW-1], cam_ff[CW*k +: CW]});
      end
   end

   // Stage 2: direction sum, split into sign and magnitude.
   logic signed [D_W-1:0] d_in [3];
   logic [D_W-1:0]        mag_in [3];
   logic [D_W-1:0]        s2_mag_ff [3];
   logic [2:0]            s2_neg_ff;
   logic                  s2_valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k]   = (D_W'(s1_base_ff[k]) <<< cprd_pkg::JIT_W)
                   + D_W'(s1_pc_ff[k]) + D_W'(s1_pr_ff[k]);
         mag_in[k] = d_in[k][D_W-1] ? D_W'(-d_in[k]) : D_W'(d_in[k]);
      end
   end

   // Stage 3: leading one of the largest magnitude (same as that of the OR).
   logic [D_W-1:0]   or_w;
   logic [POS_W-1:0] pos_in;
   logic [D_W-1:0]   s3_mag_ff [3];
   logic [2:0]       s3_neg_ff;
   logic [POS_W-1:0] s3_pos_ff;
   logic             s3_zero_ff;
   logic             s3_valid_ff;

   always_comb begin
      or_w   = s2_mag_ff[0] | s2_mag_ff[1] | s2_mag_ff[2];
      pos_in = '0;
      for (int i = 0; i < D_W; i++) begin
         if (or_w[i]) pos_in = POS_W'(i);
      end
   end

   // Stage 4: common shift so the largest magnitude lands in [2^29, 2^30).
   logic [NW-1:0]  norm_in [3];
   logic [NW-1:0]  s4_norm_ff [3];
   logic [2:0]     s4_neg_ff;
   logic           s4_zero_ff;
   logic           s4_valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (s3_pos_ff >= POS_W'(cprd_pkg::NORM_TOP)) begin
            norm_in[k] = NW'(s3_mag_ff[k] >> (s3_pos_ff - POS_W'(cprd_pkg::NORM_TOP)));
         end else begin
            norm_in[k] = NW'(s3_mag_ff[k] << (POS_W'(cprd_pkg::NORM_TOP) - s3_pos_ff));
         end
      end
   end

   // Stage 5: squares. Stage 6: sum of squares.
   logic [SQ_W-1:0]            s5_sq_ff [3];
   logic [NW-1:0]              s5_norm_ff [3];
   logic [2:0]                 s5_neg_ff;
   logic                       s5_zero_ff;
   logic                       s5_valid_ff;
   logic [cprd_pkg::SUM_W-1:0] s6_sum_ff;
   logic [NW-1:0]              s6_norm_ff [3];
   logic [2:0]                 s6_neg_ff;
   logic                       s6_zero_ff;
   logic                       s6_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pc_ff   <= pc_in;
         s1_pr_ff   <= pr_in;
         s1_base_ff <= base_in;
         s2_mag_ff  <= mag_in;
         for (int k = 0; k < 3; k++) s2_neg_ff[k] <= d_in[k][D_W-1];
         s3_mag_ff  <= s2_mag_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_pos_ff  <= pos_in;
         s3_zero_ff <= (or_w == '0);
         s4_norm_ff <= norm_in;
         s4_neg_ff  <= s3_neg_ff;
         s4_zero_ff <= s3_zero_ff;
         for (int k = 0; k < 3; k++) s5_sq_ff[k] <= SQ_W'(s4_norm_ff[k]) * SQ_W'(s4_norm_ff[k]);
         s5_norm_ff <= s4_norm_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_zero_ff <= s4_zero_ff;
         s6_sum_ff  <= cprd_pkg::SUM_W'(s5_sq_ff[0]) + cprd_pkg::SUM_W'(s5_sq_ff[1])
                     + cprd_pkg::SUM_W'(s5_sq_ff[2]);
         s6_norm_ff <= s5_norm_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_zero_ff <= s5_zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Length by square root.
   logic                       sq_valid;
   logic [cprd_pkg::LEN_W-1:0] sq_len;
   logic [SIDE_S-1:0]          sq_side;

   cprd_isqrt #(.SIDE_W(SIDE_S)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_value  (s6_sum_ff),
      .in_side   ({s6_zero_ff, s6_neg_ff, s6_norm_ff[2], s6_norm_ff[1], s6_norm_ff[0]}),
      .out_valid (sq_valid),
      .out_root  (sq_len),
      .out_side  (sq_side)
   );

   // Dividend with half the length added for rounding.
   logic [cprd_pkg::DIV_W-1:0] pp_num_ff [3];
   logic [cprd_pkg::LEN_W-1:0] pp_den_ff;
   logic [SIDE_D-1:0]          pp_side_ff;
   logic                       pp_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pp_num_ff[k] <= cprd_pkg::DIV_W'({sq_side[NW*k +: NW], {cprd_pkg::FRAC_W{1'b0}}})
                          + cprd_pkg::DIV_W'(sq_len >> 1);
         end
         pp_den_ff  <= sq_len;
         pp_side_ff <= sq_side[SIDE_S-1 -: SIDE_D];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else if (en) begin
         pp_valid_ff <= sq_valid;
      end
   end

   logic                      dv_valid;
   logic [cprd_pkg::Q_W-1:0]  dv_quo [3];
   logic [SIDE_D-1:0]         dv_side;

   cprd_div #(.SIDE_W(SIDE_D)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pp_valid_ff),
      .in_num    (pp_num_ff),
      .in_den    (pp_den_ff),
      .in_side   (pp_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Clamp, apply sign, and force zeros for a zero-length direction.
   logic [cprd_pkg::Q_W-1:0] qc [3];
   logic [cprd_pkg::Q_W-1:0] dir_w [3];
   cprd_pkg::rsp_type        fin;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qc[k] = (dv_quo[k] > cprd_pkg::Q_ONE) ? cprd_pkg::Q_ONE : dv_quo[k];
         if (dv_side[SIDE_D-1]) begin
            dir_w[k] = '0;
         end else begin
            dir_w[k] = dv_side[k] ? (~qc[k] + 1'b1) : qc[k];
         end
      end
      fin.dir_x      = $signed(dir_w[0]);
      fin.dir_y      = $signed(dir_w[1]);
      fin.dir_z      = $signed(dir_w[2]);
      fin.degenerate = dv_side[SIDE_D-1];
   end

   // Output register plus skid entry.
   cprd_pkg::rsp_type out_ff, skid_ff;
   logic              out_valid_ff;
   logic              push, pop;

   assign push = en && dv_valid;
   assign pop  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= fin;
         end else begin
            skid_ff <= fin;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_dir_x      = out_ff.dir_x;
   assign rsp_dir_y      = out_ff.dir_y;
   assign rsp_dir_z      = out_ff.dir_z;
   assign rsp_degenerate = out_ff.degenerate;

endmodule

### rtl/core/cprd_check.sv
// Port-level checks of the camera primary ray direction unit, and their bind.
// Depends on cprd_pkg and on the top level's port list.
module cprd_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [cprd_pkg::Q_W-1:0]   rsp_dir_x,
   input  logic signed [cprd_pkg::Q_W-1:0]   rsp_dir_y,
   input  logic signed [cprd_pkg::Q_W-1:0]   rsp_dir_z,
   input  logic                              rsp_degenerate
);

   localparam logic signed [cprd_pkg::Q_W-1:0] LIM = cprd_pkg::Q_ONE;

   // Reset leaves no response beat pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A zero-length direction reports all components as zero.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0)
      else $error("degenerate beat with nonzero direction");

   // Unit components never exceed one in magnitude.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_x >= -LIM && rsp_dir_x <= LIM && rsp_dir_y >= -LIM
         && rsp_dir_y <= LIM && rsp_dir_z >= -LIM && rsp_dir_z <= LIM)
      else $error("direction component out of range");

endmodule

bind camera_primary_ray_direction_unit cprd_check u_cprd_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_dir_x      (rsp_dir_x),
   .rsp_dir_y      (rsp_dir_y),
   .rsp_dir_z      (rsp_dir_z),
   .rsp_degenerate (rsp_degenerate)
);

### verif/tb_camera_primary_ray_direction_unit.sv
// Self-checking testbench for camera_primary_ray_direction_unit: predicts each unit
// ray direction from its own register copy and compares every response beat.
// Depends on cprd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_camera_primary_ray_direction_unit;

   localparam int COORD_BITS = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 5000;
   localparam logic [cprd_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd4;

   typedef struct packed {
      logic [COORD_BITS-1:0]          column;
      logic [COORD_BITS-1:0]          row;
      logic [cprd_pkg::JIT_W-1:0]     jitter_x;
      logic [cprd_pkg::JIT_W-1:0]     jitter_y;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_BITS-1:0] req_column = '0;
   logic [COORD_BITS-1:0] req_row = '0;
   logic [cprd_pkg::JIT_W-1:0] req_jitter_x = '0;
   logic [cprd_pkg::JIT_W-1:0] req_jitter_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [cprd_pkg::Q_W-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic rsp_degenerate;
   logic csr_we = 1'b0;
   logic [cprd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cprd_pkg::REG_W-1:0] csr_wdata = '0;

   logic [cprd_pkg::REG_W-1:0] camera_q, corner_q, col_step_q, row_step_q;
   pixel_type pending_pixels[$];
   cprd_pkg::rsp_type expected_dirs[$];
   pixel_type on_bus;
   bit failed = 0;
   int gap_left = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int idle_cycles = 0;

   camera_primary_ray_direction_unit #(.COORD_BITS(COORD_BITS)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > s) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (s >= res + bit_v) begin
            s = s - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic cprd_pkg::rsp_type predict_ray(pixel_type p);
      logic signed [63:0] cx, cy, cam, cor, cs, rs, d;
      logic [63:0] mag[3];
      logic neg[3];
      logic [63:0] peak, ssq, len, q;
      logic [cprd_pkg::Q_W-1:0] outv[3];
      cprd_pkg::rsp_type r;
      cx = {36'd0, p.column, p.jitter_x};
      cy = {36'd0, p.row, p.jitter_y};
      peak = 0;
      for (int k = 0; k < 3; k++) begin
         cam = $signed(camera_q[16*k +: 16]);
         cor = $signed(corner_q[16*k +: 16]);
         cs  = $signed(col_step_q[16*k +: 16]);
         rs  = $signed(row_step_q[16*k +: 16]);
         d = (cor - cam) * 64'sd65536 + cs * cx + rs * cy;
         neg[k] = d < 0;
         mag[k] = neg[k] ? 64'(-d) : 64'(d);
         if (mag[k] > peak) peak = mag[k];
      end
      r = '0;
      if (peak == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      while (peak >= (64'd1 << 30)) begin
         peak = peak >> 1;
         for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      end
      while (peak < (64'd1 << 29)) begin
         peak = peak << 1;
         for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
      end
      ssq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(ssq);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 64'd16384 + (len >> 1)) / len;
         if (q > 64'd16384) q = 64'd16384;
         outv[k] = neg[k] ? 16'(64'd0 - q) : q[15:0];
      end
      r.dir_x = outv[0];
      r.dir_y = outv[1];
      r.dir_z = outv[2];
      return r;
   endfunction

   // Request driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      pixel_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_dirs.push_back(predict_ray(on_bus));
         if (req_valid && !req_ready) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            nxt = pending_pixels.pop_front();
            on_bus <= nxt;
            req_column <= nxt.column;
            req_row <= nxt.row;
            req_jitter_x <= nxt.jitter_x;
            req_jitter_y <= nxt.jitter_y;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor with its own stall pattern.
   always @(posedge clock) begin
      cprd_pkg::rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dirs.size() == 0) begin
               $error("response beat with no expected direction");
               failed = 1;
            end else begin
               exp_r = expected_dirs.pop_front();
               if (rsp_dir_x !== exp_r.dir_x) begin
                  $error("dir_x expected %0d actual %0d", exp_r.dir_x, rsp_dir_x);
                  failed = 1;
               end
               if (rsp_dir_y !== exp_r.dir_y) begin
                  $error("dir_y expected %0d actual %0d", exp_r.dir_y, rsp_dir_y);
                  failed = 1;
               end
               if (rsp_dir_z !== exp_r.dir_z) begin
                  $error("dir_z expected %0d actual %0d", exp_r.dir_z, rsp_dir_z);
                  failed = 1;
               end
               if (rsp_degenerate !== exp_r.degenerate) begin
                  $error("degenerate expected %0d actual %0d",
                         exp_r.degenerate, rsp_degenerate);
                  failed = 1;
               end
            end
         end
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 31) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("camera_primary_ray_direction_unit: mismatch");
         $finish;
      end
   end

   task automatic write_reg(logic [cprd_pkg::CSR_IDX_W-1:0] idx,
                            logic [cprd_pkg::REG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         cprd_pkg::CSR_CAMERA_POSITION: camera_q = val;
         cprd_pkg::CSR_FRAME_CORNER:    corner_q = val;
         cprd_pkg::CSR_COLUMN_STEP:     col_step_q = val;
         cprd_pkg::CSR_ROW_STEP:        row_step_q = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      wait (pending_pixels.size() == 0 && !req_valid && expected_dirs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(int c, int r, int jx, int jy);
      pixel_type p;
      p.column = COORD_BITS'(c);
      p.row = COORD_BITS'(r);
      p.jitter_x = cprd_pkg::JIT_W'(jx);
      p.jitter_y = cprd_pkg::JIT_W'(jy);
      pending_pixels.push_back(p);
   endtask

   function automatic logic [cprd_pkg::REG_W-1:0] rand_reg();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic random_pixels(int n);
      int c, r;
      for (int i = 0; i < n; i++) begin
         c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
         r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
         if ($urandom_range(0, 1))
            add_pixel(c, r, 0, 0);
         else
            add_pixel(c, r, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
   endtask

   initial begin
      camera_q = cprd_pkg::CAMERA_POSITION_RST;
      corner_q = cprd_pkg::FRAME_CORNER_RST;
      col_step_q = cprd_pkg::COLUMN_STEP_RST;
      row_step_q = cprd_pkg::ROW_STEP_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset registers.
      add_pixel(0, 0, 0, 0);
      add_pixel(4095, 4095, 0, 0);
      add_pixel(4095, 4095, 65535, 65535);
      add_pixel(0, 4095, 65535, 0);
      add_pixel(4095, 0, 0, 65535);
      add_pixel(128, 128, 32768, 32768);
      add_pixel(2730, 1365, 43690, 21845);
      add_pixel(1365, 2730, 21845, 43690);
      random_pixels(60);
      drain();

      // Corner equal to camera: the pixel at column 0, row 0 gives a zero-length direction.
      write_reg(cprd_pkg::CSR_FRAME_CORNER, camera_q);
      write_reg(CSR_FIRST_UNUSED, rand_reg());
      add_pixel(0, 0, 0, 0);
      add_pixel(1, 0, 0, 0);
      add_pixel(0, 1, 0, 0);
      add_pixel(0, 0, 1, 1);
      random_pixels(30);
      drain();
      write_reg(cprd_pkg::CSR_COLUMN_STEP, '0);
      write_reg(cprd_pkg::CSR_ROW_STEP, '0);
      add_pixel(4095, 4095, 65535, 65535);
      add_pixel(0, 0, 0, 0);
      random_pixels(10);
      drain();

      // Register extremes.
      write_reg(cprd_pkg::CSR_CAMERA_POSITION, {3{16'h8000}});
      write_reg(cprd_pkg::CSR_FRAME_CORNER, {3{16'h7FFF}});
      write_reg(cprd_pkg::CSR_COLUMN_STEP, {3{16'h7FFF}});
      write_reg(cprd_pkg::CSR_ROW_STEP, {3{16'h7FFF}});
      add_pixel(4095, 4095, 65535, 65535);
      random_pixels(40);
      drain();
      write_reg(cprd_pkg::CSR_CAMERA_POSITION, {3{16'h7FFF}});
      write_reg(cprd_pkg::CSR_FRAME_CORNER, {3{16'h8000}});
      write_reg(cprd_pkg::CSR_COLUMN_STEP, {3{16'h8000}});
      write_reg(cprd_pkg::CSR_ROW_STEP, {3{16'h8000}});
      add_pixel(4095, 4095, 65535, 65535);
      random_pixels(40);
      drain();
      write_reg(cprd_pkg::CSR_CAMERA_POSITION, {cprd_pkg::REG_W{1'b1}});
      write_reg(cprd_pkg::CSR_FRAME_CORNER, '0);
      write_reg(cprd_pkg::CSR_COLUMN_STEP, {cprd_pkg::REG_W{1'b1}});
      write_reg(cprd_pkg::CSR_ROW_STEP, '0);
      random_pixels(30);
      drain();

      // Random register settings.
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(cprd_pkg::CSR_CAMERA_POSITION, rand_reg());
         write_reg(cprd_pkg::CSR_FRAME_CORNER, rand_reg());
         write_reg(cprd_pkg::CSR_COLUMN_STEP, rand_reg());
         write_reg(cprd_pkg::CSR_ROW_STEP, rand_reg());
         write_reg(cprd_pkg::CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, 7)), rand_reg());
         random_pixels(55);
         drain();
      end

      if (!failed)
         $display("camera_primary_ray_direction_unit: match");
      else
         $display("camera_primary_ray_direction_unit: mismatch");
      $finish;
   end

endmodule
